[sv/ate_pkg.sv]
// Shared types and constants for the array table search and edit block.
`default_nettype none

package ate_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int FILL_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_FIND    = 3'd0,
        OP_REPLACE = 3'd1,
        OP_APPEND  = 3'd2,
        OP_ZERO    = 3'd3,
        OP_DELETE  = 3'd4
    } op_e_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_e_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_SHIFT,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        status_e_t                 status;
        logic [POS_W-1:0]          found;
        logic signed [DATA_W-1:0]  res_value;
        logic [FILL_W-1:0]         res_count;
    } result_t;

endpackage

`default_nettype wire

[sv/ate_ram.sv]
// Entry store: one write port and one registered read port.
`default_nettype none

module ate_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/ate_ctrl.sv]
// Request sequencer: scan, shift and single-write edits over the entry store.
`default_nettype none

module ate_ctrl #(
    parameter int CAPACITY = 64,
    parameter int IW       = 6
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic [ate_pkg::OP_W-1:0]     req_op,
    input  wire logic [ate_pkg::DATA_W-1:0]   req_value,
    input  wire logic [ate_pkg::DATA_W-1:0]   req_repl,
    input  wire logic [ate_pkg::POS_W-1:0]    req_pos,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output ate_pkg::result_t                  res,
    output logic                              mem_we,
    output logic [IW-1:0]                     mem_waddr,
    output logic [ate_pkg::DATA_W-1:0]        mem_wdata,
    output logic [IW-1:0]                     mem_raddr,
    input  wire logic [ate_pkg::DATA_W-1:0]   mem_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > ate_pkg::FILL_W) ? CW : ate_pkg::FILL_W;

    ate_pkg::ctrl_state_t             state_reg, state_next;
    logic [ate_pkg::OP_W-1:0]         op_reg, op_next;
    logic [ate_pkg::DATA_W-1:0]       value_reg, value_next;
    logic [ate_pkg::DATA_W-1:0]       repl_reg, repl_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    rd_idx_reg, rd_idx_next;
    logic                             chk_reg, chk_next;
    logic [CW-1:0]                    chk_idx_reg, chk_idx_next;
    ate_pkg::result_t                 res_reg, res_next;
    logic [EW-1:0]                    pos_w;

    assign pos_w = EW'(req_pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ate_pkg::CS_IDLE;
            count_reg <= '0;
            chk_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
        end
        op_reg      <= op_next;
        value_reg   <= value_next;
        repl_reg    <= repl_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        res_reg     <= res_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        repl_next    = repl_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        chk_next     = chk_reg;
        chk_idx_next = chk_idx_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = rd_idx_reg[IW-1:0];
        req_ready    = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            ate_pkg::CS_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next             = req_op;
                    value_next          = req_value;
                    repl_next           = req_repl;
                    rd_idx_next         = '0;
                    chk_next            = 1'b0;
                    res_next.status     = ate_pkg::ST_OK;
                    res_next.found      = '0;
                    res_next.res_value  = '0;
                    res_next.res_count  = ate_pkg::FILL_W'(count_reg);
                    state_next          = ate_pkg::CS_DONE;
                    case (ate_pkg::op_e_t'(req_op))
                        ate_pkg::OP_FIND, ate_pkg::OP_REPLACE: begin
                            state_next = ate_pkg::CS_SCAN;
                        end
                        ate_pkg::OP_APPEND: begin
                            if (count_reg < CW'(CAPACITY)) begin
                                mem_we             = 1'b1;
                                mem_waddr          = count_reg[IW-1:0];
                                mem_wdata          = req_value;
                                count_next         = CW'(count_reg + 1'b1);
                                res_next.res_count = ate_pkg::FILL_W'(count_next);
                            end else begin
                                res_next.status = ate_pkg::ST_FULL;
                            end
                        end
                        ate_pkg::OP_ZERO: begin
                            if (pos_w < EW'(CAPACITY)) begin
                                mem_we    = 1'b1;
                                mem_waddr = IW'(pos_w);
                            end else begin
                                res_next.status = ate_pkg::ST_BAD_POS;
                            end
                        end
                        ate_pkg::OP_DELETE: begin
                            if (pos_w < EW'(count_reg)) begin
                                rd_idx_next = CW'(pos_w + EW'(1));
                                state_next  = ate_pkg::CS_SHIFT;
                            end else begin
                                res_next.status = ate_pkg::ST_BAD_POS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ate_pkg::CS_SCAN: begin
                if (chk_reg && (mem_rdata == value_reg)) begin
                    res_next.found = ate_pkg::POS_W'(chk_idx_reg);
                    if (ate_pkg::op_e_t'(op_reg) == ate_pkg::OP_REPLACE) begin
                        mem_we             = 1'b1;
                        mem_waddr          = chk_idx_reg[IW-1:0];
                        mem_wdata          = repl_reg;
                        res_next.res_value = repl_reg;
                    end
                    chk_next   = 1'b0;
                    state_next = ate_pkg::CS_DONE;
                end else if (rd_idx_reg < count_reg) begin
                    chk_next     = 1'b1;
                    chk_idx_next = rd_idx_reg;
                    rd_idx_next  = CW'(rd_idx_reg + 1'b1);
                end else begin
                    res_next.status = ate_pkg::ST_NOT_FOUND;
                    chk_next        = 1'b0;
                    state_next      = ate_pkg::CS_DONE;
                end
            end
            ate_pkg::CS_SHIFT: begin
                chk_next = 1'b0;
                if (chk_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_idx_reg[IW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (rd_idx_reg < count_reg) begin
                    chk_next     = 1'b1;
                    chk_idx_next = CW'(rd_idx_reg - 1'b1);
                    rd_idx_next  = CW'(rd_idx_reg + 1'b1);
                end else if (!chk_reg) begin
                    count_next         = CW'(count_reg - 1'b1);
                    res_next.res_count = ate_pkg::FILL_W'(count_next);
                    state_next         = ate_pkg::CS_DONE;
                end
            end
            ate_pkg::CS_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ate_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = ate_pkg::CS_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[sv/array_table_search_edit.sv]
// Top level of the array table search and edit block.
// Keeps a bounded list of CAPACITY signed 32-bit words and a fill count, and
// answers one result per request: find, replace first match, append, zero at a
// position, or delete at a position. All entries sit in one memory with a
// single registered read port, so a find or replace walks the list one entry a
// cycle, and a delete shifts each later entry down one place. Results pass
// through an output register, which lets a new request enter while the
// previous result waits to be taken. Entries are not cleared at reset; only
// the fill count is.
`default_nettype none

module array_table_search_edit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ate_pkg::OP_W-1:0]          s_op,
    input  wire logic signed [ate_pkg::DATA_W-1:0] s_value,
    input  wire logic signed [ate_pkg::DATA_W-1:0] s_replacement,
    input  wire logic [ate_pkg::POS_W-1:0]         s_position,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_status,
    output logic [ate_pkg::POS_W-1:0]              m_found_position,
    output logic signed [ate_pkg::DATA_W-1:0]      m_result_value,
    output logic [ate_pkg::FILL_W-1:0]             m_fill_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                          res_valid;
    logic                          res_ready;
    ate_pkg::result_t              res;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [ate_pkg::DATA_W-1:0]    mem_wdata;
    logic [IW-1:0]                 mem_raddr;
    logic [ate_pkg::DATA_W-1:0]    mem_rdata;
    logic                          m_valid_reg, m_valid_next;
    ate_pkg::result_t              out_reg, out_next;

    ate_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_op    (s_op),
        .req_value (s_value),
        .req_repl  (s_replacement),
        .req_pos   (s_position),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ate_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (ate_pkg::DATA_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_found_position = out_reg.found;
    assign m_result_value   = out_reg.res_value;
    assign m_fill_count     = out_reg.res_count;

    a_req_blocks_next : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous request still in progress");

    a_idle_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("result offered while sequencer idle");

    a_full_count : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ate_pkg::ST_FULL) |->
            (m_fill_count == ate_pkg::FILL_W'(CAPACITY)))
        else $error("full status with fill count below capacity");

    a_not_found_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ate_pkg::ST_NOT_FOUND) |->
            (m_found_position == '0) && (m_result_value == '0))
        else $error("not-found result carries position or value");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking bench for the array table search and edit block: directed edits, then shaped random traffic.
`timescale 1ns / 100ps

module testbench;
    import ate_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 10;
    localparam int LONG_HOLD    = 500;
    localparam int HOLD_AFTER   = 300;

    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam logic signed [DATA_W-1:0] W_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] W_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] W_ONES = 32'shFFFF_FFFF;

    typedef struct packed {
        status_e_t                status;
        logic [POS_W-1:0]         where_found;
        logic signed [DATA_W-1:0] written;
        logic [FILL_W-1:0]        fill;
    } list_reply_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] repl;
        logic [POS_W-1:0]         pos;
        logic                     typed;
        list_reply_t              reply;
    } edit_row_t;

    localparam int N_DIRECTED = 24;

    edit_row_t directed_rows [N_DIRECTED] = '{
        '{OP_FIND,    32'sd5, 32'sd0, 6'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'sd0, 7'd0}},
        '{OP_REPLACE, 32'sd5, 32'sd7, 6'd0,  1'b1, '{ST_NOT_FOUND, 6'd0, 32'sd0, 7'd0}},
        '{OP_DELETE,  32'sd0, 32'sd0, 6'd0,  1'b1, '{ST_BAD_POS,   6'd0, 32'sd0, 7'd0}},
        '{OP_DELETE,  W_ONES, W_ONES, 6'd63, 1'b1, '{ST_BAD_POS,   6'd0, 32'sd0, 7'd0}},
        '{OP_ZERO,    32'sd0, 32'sd0, 6'd63, 1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd0}},
        '{OP_ZERO,    32'sd0, 32'sd0, 6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd0}},
        '{OP_SPARE5,  W_ONES, W_ONES, 6'd63, 1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd0}},
        '{OP_SPARE6,  W_MIN,  W_MAX,  6'd42, 1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd0}},
        '{OP_SPARE7,  W_ONES, W_ONES, 6'd63, 1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd0}},
        '{OP_APPEND,  W_MIN,  W_ONES, 6'd63, 1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd1}},
        '{OP_APPEND,  W_MAX,  32'sd0, 6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd2}},
        '{OP_APPEND,  W_ONES, 32'sd0, 6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd3}},
        '{OP_APPEND,  32'sd0, 32'sd0, 6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd4}},
        '{OP_APPEND,  W_ONES, 32'sd0, 6'd0,  1'b1, '{ST_OK,        6'd0, 32'sd0, 7'd5}},
        '{OP_FIND,    W_MAX,  32'sd0, 6'd0,  1'b0, '0},
        '{OP_FIND,    W_ONES, 32'sd0, 6'd0,  1'b0, '0},
        '{OP_REPLACE, W_ONES, W_MIN,  6'd0,  1'b0, '0},
        '{OP_FIND,    W_ONES, 32'sd0, 6'd0,  1'b0, '0},
        '{OP_FIND,    W_MIN,  32'sd0, 6'd0,  1'b0, '0},
        '{OP_ZERO,    32'sd0, 32'sd0, 6'd1,  1'b0, '0},
        '{OP_FIND,    32'sd0, 32'sd0, 6'd0,  1'b0, '0},
        '{OP_DELETE,  32'sd0, 32'sd0, 6'd0,  1'b0, '0},
        '{OP_DELETE,  32'sd0, 32'sd0, 6'd4,  1'b1, '{ST_BAD_POS,   6'd0, 32'sd0, 7'd4}},
        '{OP_DELETE,  32'sd0, 32'sd0, 6'd3,  1'b0, '0}
    };

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op          = '0;
    logic signed [DATA_W-1:0] s_value       = '0;
    logic signed [DATA_W-1:0] s_replacement = '0;
    logic [POS_W-1:0]         s_position    = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [1:0]               m_status;
    logic [POS_W-1:0]         m_found_position;
    logic signed [DATA_W-1:0] m_result_value;
    logic [FILL_W-1:0]        m_fill_count;

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;
    list_reply_t              pending_replies [$];

    int errors         = 0;
    int requests_sent  = 0;
    int replies_taken  = 0;
    int full_reached   = 0;
    int op_tally [8]   = '{default: 0};
    int status_tally [4] = '{default: 0};
    bit sender_burst   = 1'b0;

    array_table_search_edit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_value         (s_value),
        .s_replacement   (s_replacement),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_position(m_found_position),
        .m_result_value  (m_result_value),
        .m_fill_count    (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic list_reply_t apply_list_edit(input logic [OP_W-1:0] op,
                                                    input logic signed [DATA_W-1:0] value,
                                                    input logic signed [DATA_W-1:0] repl,
                                                    input logic [POS_W-1:0] pos);
        list_reply_t r;
        int          hit;
        r   = '{status: ST_OK, where_found: '0, written: '0, fill: '0};
        hit = -1;
        if (op == OP_FIND || op == OP_REPLACE) begin
            for (int i = list_len - 1; i >= 0; i--) begin
                if (list_mem[i] == value) hit = i;
            end
        end
        case (op)
            OP_FIND: begin
                if (hit < 0) r.status = ST_NOT_FOUND;
                else r.where_found = POS_W'(hit);
            end
            OP_REPLACE: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    list_mem[hit] = repl;
                    r.where_found = POS_W'(hit);
                    r.written     = repl;
                end
            end
            OP_APPEND: begin
                if (list_len < CAPACITY) begin
                    list_mem[list_len] = value;
                    list_len++;
                    if (list_len == CAPACITY) full_reached++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_ZERO: begin
                if (int'(pos) < CAPACITY) list_mem[pos] = '0;
                else r.status = ST_BAD_POS;
            end
            OP_DELETE: begin
                if (int'(pos) < list_len) begin
                    for (int i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                end else begin
                    r.status = ST_BAD_POS;
                end
            end
            default: ;
        endcase
        r.fill = FILL_W'(list_len);
        return r;
    endfunction

    function automatic int pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45 && list_len != 0) return list_mem[$urandom_range(0, list_len - 1)];
        if (r < 70) begin
            case ($urandom_range(0, 5))
                0: return W_MIN;
                1: return W_MAX;
                2: return W_ONES;
                3: return '0;
                default: return DATA_W'($urandom_range(1, 7));
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return OP_FIND;
        if (r < 45) return OP_REPLACE;
        if (r < 65) return OP_APPEND;
        if (r < 75) return OP_ZERO;
        if (r < 95) return OP_DELETE;
        return OP_W'($urandom_range(int'(OP_SPARE5), int'(OP_SPARE7)));
    endfunction

    task automatic offer_request(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] value,
                                 input logic signed [DATA_W-1:0] repl,
                                 input logic [POS_W-1:0] pos,
                                 input logic typed,
                                 input list_reply_t typed_reply);
        list_reply_t predicted;
        int          gap;
        s_valid       <= 1'b1;
        s_op          <= op;
        s_value       <= value;
        s_replacement <= repl;
        s_position    <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_list_edit(op, value, repl, pos);
        pending_replies.push_back(typed ? typed_reply : predicted);
        op_tally[op]++;
        requests_sent++;
        gap = pick_gap(sender_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic offer(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                         input logic signed [DATA_W-1:0] repl, input logic [POS_W-1:0] pos);
        offer_request(op, value, repl, pos, 1'b0, '0);
    endtask

    task automatic offer_shaped(input logic [OP_W-1:0] op);
        logic [POS_W-1:0] pos;
        if (op == OP_DELETE && list_len != 0 && $urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(0, list_len - 1));
        else
            pos = POS_W'($urandom_range(0, CAPACITY - 1));
        offer(op, pick_word(), pick_word(), pos);
    endtask

    task automatic drain_pending();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    task automatic take_reply();
        list_reply_t exp;
        status_tally[m_status]++;
        replies_taken++;
        if (pending_replies.size() == 0) begin
            $error("result with no request outstanding: status %0d, fill_count %0d",
                   m_status, m_fill_count);
            errors++;
            return;
        end
        exp = pending_replies.pop_front();
        if (m_status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, m_status);
            errors++;
        end
        if (m_found_position !== exp.where_found) begin
            $error("found_position: expected %0d, got %0d", exp.where_found, m_found_position);
            errors++;
        end
        if (m_result_value !== exp.written) begin
            $error("result_value: expected %0d, got %0d", exp.written, m_result_value);
            errors++;
        end
        if (m_fill_count !== exp.fill) begin
            $error("fill_count: expected %0d, got %0d", exp.fill, m_fill_count);
            errors++;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        bit rx_burst;
        bit hold_done;
        stall_left = 0;
        rx_burst   = 1'b0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) take_reply();
            if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
            if (!hold_done && replies_taken >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!rx_burst && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap(1'b0);
                m_ready <= (stall_left == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("No handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_replies.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int kind;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].repl,
                          directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].reply);
        end
        drain_pending();

        while (requests_sent < N_DIRECTED + RANDOM_ITEMS) begin
            sender_burst = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 4) == 0) drain_pending();
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                // fill to capacity, then push against the full list
                while (list_len < CAPACITY) begin
                    if ($urandom_range(0, 4) == 0) offer_shaped(pick_op());
                    else offer_shaped(OP_APPEND);
                end
                repeat ($urandom_range(1, 3)) offer_shaped(OP_APPEND);
                repeat ($urandom_range(4, 10)) offer_shaped(pick_op());
            end else if (kind < 5) begin
                // drain to empty, then poke the empty list
                while (list_len != 0) begin
                    if ($urandom_range(0, 4) == 0) offer_shaped(pick_op());
                    else offer_shaped(OP_DELETE);
                end
                repeat ($urandom_range(1, 3)) offer_shaped(pick_op());
            end else if (kind < 9) begin
                repeat ($urandom_range(20, 60)) offer_shaped(pick_op());
            end else begin
                repeat ($urandom_range(5, 15)) begin
                    offer(OP_W'($urandom_range(0, 7)), $urandom, $urandom,
                          POS_W'($urandom_range(0, CAPACITY - 1)));
                end
            end
        end

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: find %0d, replace %0d, append %0d, zero %0d, delete %0d, %s %0d",
                 requests_sent, op_tally[OP_FIND], op_tally[OP_REPLACE], op_tally[OP_APPEND],
                 op_tally[OP_ZERO], op_tally[OP_DELETE], "unused codes",
                 op_tally[OP_SPARE5] + op_tally[OP_SPARE6] + op_tally[OP_SPARE7]);
        $display("Checked %0d results: ok %0d, not found %0d, full %0d, bad position %0d; %s %0d",
                 replies_taken, status_tally[ST_OK], status_tally[ST_NOT_FOUND],
                 status_tally[ST_FULL], status_tally[ST_BAD_POS], "list filled to capacity",
                 full_reached);
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
